// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of the color enhancement core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HHCE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define HHCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/hhce_pkg.sv -----
// Shared constants and types of the HSV hue-curve color enhancement core.
// No dependencies.
package hhce_pkg;

  localparam int HUE_FRAC_BITS   = 8;
  localparam int COLOR_FRAC_BITS = 16;
  localparam int GAIN_FRAC       = 8;

  localparam int HUE_W = 17;   // degrees, 8 fractional bits, below 360
  localparam int CLR_W = 17;   // S and V, one = 2^16
  localparam int SQ_W  = 17;
  localparam int LIN_W = 19;
  localparam int GAIN_W = 12;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CLR_W-1:0] CLR_ONE   = CLR_W'(1 << COLOR_FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_SIXTY = HUE_W'(60 << HUE_FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_120   = HUE_W'(120 << HUE_FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_240   = HUE_W'(240 << HUE_FRAC_BITS);
  localparam logic [HUE_W-1:0] HUE_360   = HUE_W'(360 << HUE_FRAC_BITS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_SQUARE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_LINEAR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_GAIN   = CFG_IDX_W'(3);

  // Register reset values
  localparam logic signed [SQ_W-1:0]  RST_HUE_SQUARE = -SQ_W'(786);
  localparam logic signed [LIN_W-1:0] RST_HUE_LINEAR = LIN_W'(187433);
  localparam logic [GAIN_W-1:0]       RST_GAIN       = GAIN_W'(512);

  // Channel that holds the maximum
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // Modulo 45 by reciprocal: bias makes the signed turn count positive
  localparam logic [17:0]  MOD_BIAS   = 18'd32805;   // 45 * 729
  localparam logic [27:0]  MOD_RECIP  = 28'd1456;    // floor(2^16 / 45)
  localparam logic [16:0]  MOD_DIV    = 17'd45;
  // Divide by 15 by reciprocal: floor(2^25 / 15)
  localparam logic [42:0]  SF_RECIP   = 43'd2236962;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CLR_W-1:0] sat;
    logic [CLR_W-1:0] val;
  } hsv_t;

endpackage

// ----- rtl/core/hhce_div_pipe.sv -----
// Pipelined restoring divider: one quotient bit per stage, with sideband.
// No package dependencies.
module hhce_div_pipe #(
  parameter int NUM_W  = 25,
  parameter int DEN_W  = 8,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_vld,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld    [NUM_W];
  logic [DEN_W-1:0]  rem    [NUM_W];
  logic [NUM_W-1:0]  nbits  [NUM_W];
  logic [NUM_W-1:0]  quo    [NUM_W];
  logic [DEN_W-1:0]  dens   [NUM_W];
  logic [SIDE_W-1:0] sides  [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              vin;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  num_in;
    logic [NUM_W-1:0]  quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign vin     = in_vld;
      assign rem_in  = '0;
      assign num_in  = num;
      assign quo_in  = '0;
      assign den_in  = den;
      assign side_in = side;
    end else begin : g_next
      assign vin     = vld[i-1];
      assign rem_in  = rem[i-1];
      assign num_in  = nbits[i-1];
      assign quo_in  = quo[i-1];
      assign den_in  = dens[i-1];
      assign side_in = sides[i-1];
    end

    // Shift in one numerator bit, subtract when it fits
    assign trial = {rem_in, num_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i]   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nbits[i] <= {num_in[NUM_W-2:0], 1'b0};
        quo[i]   <= {quo_in[NUM_W-2:0], ge};
        dens[i]  <= den_in;
        sides[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld[NUM_W-1];
  assign quot     = quo[NUM_W-1];
  assign side_out = sides[NUM_W-1];

endmodule

// ----- rtl/core/hhce_hue_curve.sv -----
// Hue remap (a*h + b)*h wrapped into 0..360 degrees, five register stages.
// Depends on hhce_pkg.
module hhce_hue_curve (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_vld,
  input  hhce_pkg::hsv_t                      in_hsv,
  input  logic signed [hhce_pkg::SQ_W-1:0]    sq_coef,
  input  logic signed [hhce_pkg::LIN_W-1:0]   lin_coef,
  output logic                                out_vld,
  output hhce_pkg::hsv_t                      out_hsv
);
  import hhce_pkg::*;

  logic [4:0] vld;

  // Stage 1: a*h
  hsv_t               c1_hsv;
  logic signed [34:0] c1_ah;
  // Stage 2: t = floor(a*h / 2^8) + b
  hsv_t               c2_hsv;
  logic signed [27:0] c2_t;
  // Stage 3: p = t*h
  hsv_t               c3_hsv;
  logic signed [45:0] c3_p;
  // Stage 4: turn count estimate
  hsv_t               c4_hsv;
  logic [16:0]        c4_hu;
  logic [10:0]        c4_q0;
  logic [10:0]        c4_low;
  // Stage 5: result
  hsv_t               c5_hsv;

  logic signed [17:0] h_s1;
  logic signed [17:0] h_s3;
  logic signed [15:0] turns;
  logic [16:0]        hu_n;
  logic [27:0]        hm_n;
  logic [16:0]        q45;
  logic [16:0]        r0;
  logic [5:0]         r1;

  assign h_s1  = signed'({1'b0, in_hsv.hue});
  assign h_s3  = signed'({1'b0, c2_hsv.hue});
  assign turns = 16'(c3_p >>> 27);
  assign hu_n  = 17'(18'(turns) + signed'(MOD_BIAS));
  assign hm_n  = 28'(hu_n) * MOD_RECIP;
  assign q45   = 17'(c4_q0) * MOD_DIV;
  assign r0    = c4_hu - q45;
  assign r1    = (r0 >= MOD_DIV) ? 6'(r0 - MOD_DIV) : r0[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[3:0], in_vld};
    end
  end

  // Advance the five stages together
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_hsv <= in_hsv;
      c1_ah  <= 35'(sq_coef) * 35'(h_s1);
      c2_hsv <= c1_hsv;
      c2_t   <= 28'(c1_ah >>> HUE_FRAC_BITS) + 28'(lin_coef);
      c3_hsv <= c2_hsv;
      c3_p   <= 46'(c2_t) * 46'(h_s3);
      c4_hsv <= c3_hsv;
      c4_hu  <= hu_n;
      c4_q0  <= hm_n[26:16];
      c4_low <= c3_p[26:16];
      c5_hsv <= '{hue: {r1, c4_low}, sat: c4_hsv.sat, val: c4_hsv.val};
    end
  end

  assign out_vld = vld[4];
  assign out_hsv = c5_hsv;

endmodule

// ----- rtl/core/hhce_hsv2rgb.sv -----
// HSV back to 8-bit BGR, five register stages, the last one the output register.
// Depends on hhce_pkg.
module hhce_hsv2rgb (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  hhce_pkg::hsv_t in_hsv,
  output logic           out_vld,
  output logic [7:0]     blue,
  output logic [7:0]     green,
  output logic [7:0]     red
);
  import hhce_pkg::*;

  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;

  logic [4:0] vld;

  logic [2:0]        d1_sec, d2_sec, d3_sec, d4_sec;
  logic [CLR_W-1:0]  d1_s, d2_s, d3_s;
  logic [CLR_W-1:0]  d1_v, d2_v, d3_v, d4_v;
  logic [CLR_W-1:0]  d1_p, d2_p, d3_p, d4_p;
  logic [30:0]       d1_prod;
  logic [19:0]       d2_x;
  logic [17:0]       d2_q0;
  logic [CLR_W-1:0]  d3_sf;
  logic [CLR_W-1:0]  d4_q, d4_t;

  logic [2:0]        sec_n;
  logic [13:0]       f_n;
  logic [33:0]       pv_n;
  logic [42:0]       y_n;
  logic [21:0]       q15;
  logic [21:0]       r_n;
  logic [CLR_W-1:0]  one_sf;
  logic [CLR_W-1:0]  one_s_sf;
  logic [33:0]       qv_n, tv_n;
  logic [CLR_W-1:0]  ro, go, bo;

  function automatic logic [7:0] to_byte(input logic [CLR_W-1:0] c);
    logic [24:0] c255;
    c255 = {c, 8'd0} - 25'(c);
    return c255[23:16];
  endfunction

  // Sector and offset inside it
  always_comb begin
    sec_n = 3'(in_hsv.hue >= HUE_SIXTY) + 3'(in_hsv.hue >= HUE_120)
          + 3'(in_hsv.hue >= 17'(HUE_SIXTY * 3)) + 3'(in_hsv.hue >= HUE_240)
          + 3'(in_hsv.hue >= 17'(HUE_SIXTY * 5));
    f_n   = 14'(in_hsv.hue - 17'(17'(sec_n) * HUE_SIXTY));
  end

  assign pv_n     = 34'(in_hsv.val) * 34'(CLR_ONE - in_hsv.sat);
  assign y_n      = 43'(d1_prod[30:10]) * SF_RECIP;
  assign q15      = {d2_q0, 4'd0} - 22'(d2_q0);
  assign r_n      = 22'(d2_x) - q15;
  assign one_sf   = CLR_ONE - d3_sf;
  assign one_s_sf = CLR_ONE - d3_s + d3_sf;
  assign qv_n     = 34'(d3_v) * 34'(one_sf);
  assign tv_n     = 34'(d3_v) * 34'(one_s_sf);

  // Route V, P, Q, T to channels by sector
  always_comb begin
    case (d4_sec)
      SEC_0: begin ro = d4_v; go = d4_t; bo = d4_p; end
      SEC_1: begin ro = d4_q; go = d4_v; bo = d4_p; end
      SEC_2: begin ro = d4_p; go = d4_v; bo = d4_t; end
      SEC_3: begin ro = d4_p; go = d4_q; bo = d4_v; end
      SEC_4: begin ro = d4_t; go = d4_p; bo = d4_v; end
      default: begin ro = d4_v; go = d4_p; bo = d4_q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_sec  <= sec_n;
      d1_s    <= in_hsv.sat;
      d1_v    <= in_hsv.val;
      d1_p    <= pv_n[32:16];
      d1_prod <= 31'(in_hsv.sat) * 31'(f_n);
      d2_sec  <= d1_sec;
      d2_s    <= d1_s;
      d2_v    <= d1_v;
      d2_p    <= d1_p;
      d2_x    <= d1_prod[29:10];
      d2_q0   <= y_n[42:25];
      d3_sec  <= d2_sec;
      d3_s    <= d2_s;
      d3_v    <= d2_v;
      d3_p    <= d2_p;
      d3_sf   <= (r_n >= 22'd15) ? 17'(d2_q0 + 18'd1) : 17'(d2_q0);
      d4_sec  <= d3_sec;
      d4_v    <= d3_v;
      d4_p    <= d3_p;
      d4_q    <= qv_n[32:16];
      d4_t    <= tv_n[32:16];
      blue    <= to_byte(bo);
      green   <= to_byte(go);
      red     <= to_byte(ro);
    end
  end

  assign out_vld = vld[4];

endmodule

// ----- rtl/core/hsv_hue_curve_color_enhance_core.sv -----
// Stages in order: 1 front stage, 25 divider stages, 1 gain stage, 5 hue-curve
// stages, 5 back-conversion stages including the output register.
// Throughput one pixel per cycle; the whole pipeline holds while the output
// register is full and not taken. Synchronous reset clears valid bits and
// loads the register reset values.
module hsv_hue_curve_color_enhance_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        blue_in,
  input  logic [7:0]                        green_in,
  input  logic [7:0]                        red_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        blue_out,
  output logic [7:0]                        green_out,
  output logic [7:0]                        red_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hhce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hhce_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hhce_pkg::*;

  logic adv;

  logic signed [SQ_W-1:0]  hue_square_coef;
  logic signed [LIN_W-1:0] hue_linear_coef;
  logic [GAIN_W-1:0]       saturation_gain;
  logic [GAIN_W-1:0]       value_gain;

  // Front stage
  logic        s1_vld;
  logic [7:0]  s1_mx;
  logic [7:0]  s1_d;
  logic [24:0] s1_ns;
  logic [24:0] s1_nh;
  logic [3:0]  s1_hinfo;

  logic [7:0]  mx_n, mn_n, x_n, y_n, diff_n;
  logic [1:0]  sel_n;
  logic        neg_n;

  // Divider outputs
  logic        sdiv_vld, hdiv_vld;
  logic [24:0] qs, qh;
  logic [7:0]  dv_mx;
  logic [3:0]  dv_hinfo;

  logic [HUE_W-1:0] base_h, hue_n;
  logic [28:0]      sg_n;
  logic [28:0]      vg_n;
  logic [CLR_W-1:0] v_n;

  logic  s2_vld;
  hsv_t  s2_hsv;
  logic  c_vld;
  hsv_t  c_hsv;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_square_coef <= RST_HUE_SQUARE;
      hue_linear_coef <= RST_HUE_LINEAR;
      saturation_gain <= RST_GAIN;
      value_gain      <= RST_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HUE_SQUARE: hue_square_coef <= cfg_data[SQ_W-1:0];
        CFG_HUE_LINEAR: hue_linear_coef <= cfg_data[LIN_W-1:0];
        CFG_SAT_GAIN:   saturation_gain <= cfg_data[GAIN_W-1:0];
        CFG_VAL_GAIN:   value_gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Max, min and the channel pair that sets the hue
  always_comb begin
    mx_n = red_in;
    if (green_in > mx_n) mx_n = green_in;
    if (blue_in > mx_n) mx_n = blue_in;
    mn_n = red_in;
    if (green_in < mn_n) mn_n = green_in;
    if (blue_in < mn_n) mn_n = blue_in;
    if (mx_n == red_in) begin
      sel_n = SEL_RED;   x_n = green_in; y_n = blue_in;
    end else if (mx_n == green_in) begin
      sel_n = SEL_GREEN; x_n = blue_in;  y_n = red_in;
    end else begin
      sel_n = SEL_BLUE;  x_n = red_in;   y_n = green_in;
    end
    neg_n  = (x_n < y_n);
    diff_n = neg_n ? (y_n - x_n) : (x_n - y_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mx    <= mx_n;
      s1_d     <= mx_n - mn_n;
      s1_ns    <= {8'(mx_n - mn_n), 17'd0} + 25'(mx_n);
      s1_nh    <= 25'({diff_n, 14'd0}) - 25'({diff_n, 10'd0});
      s1_hinfo <= {sel_n, neg_n, (mx_n == mn_n)};
    end
  end

  // Saturation: floor((2d*2^16 + mx) / mx) / 2
  hhce_div_pipe #(.NUM_W(25), .DEN_W(8), .SIDE_W(8)) u_sdiv (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(s1_vld), .num(s1_ns), .den(s1_mx), .side(s1_mx),
    .out_vld(sdiv_vld), .quot(qs), .side_out(dv_mx)
  );

  // Hue offset: |x - y| * 60 * 2^8 / d
  hhce_div_pipe #(.NUM_W(25), .DEN_W(8), .SIDE_W(4)) u_hdiv (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(s1_vld), .num(s1_nh), .den(s1_d), .side(s1_hinfo),
    .out_vld(hdiv_vld), .quot(qh), .side_out(dv_hinfo)
  );

  // Hue from sector base, gains with clamp to one
  always_comb begin
    case (dv_hinfo[3:2])
      SEL_RED:   base_h = dv_hinfo[1] ? HUE_360 : '0;
      SEL_GREEN: base_h = HUE_120;
      default:   base_h = HUE_240;
    endcase
    if (dv_hinfo[0]) begin
      hue_n = '0;
    end else if (dv_hinfo[1]) begin
      hue_n = base_h - qh[HUE_W-1:0];
    end else begin
      hue_n = base_h + qh[HUE_W-1:0];
    end
    v_n  = 17'({dv_mx, 8'd0}) + 17'(dv_mx) + 17'(dv_mx != 8'd0);
    sg_n = 29'(qs[17:1]) * 29'(saturation_gain);
    vg_n = 29'(v_n) * 29'(value_gain);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= sdiv_vld && hdiv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_hsv.hue <= hue_n;
      s2_hsv.sat <= (sg_n[28:GAIN_FRAC] > 21'(CLR_ONE)) ? CLR_ONE : sg_n[24:GAIN_FRAC];
      s2_hsv.val <= (vg_n[28:GAIN_FRAC] > 21'(CLR_ONE)) ? CLR_ONE : vg_n[24:GAIN_FRAC];
    end
  end

  hhce_hue_curve u_curve (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(s2_vld), .in_hsv(s2_hsv),
    .sq_coef(hue_square_coef), .lin_coef(hue_linear_coef),
    .out_vld(c_vld), .out_hsv(c_hsv)
  );

  hhce_hsv2rgb u_back (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(c_vld), .in_hsv(c_hsv),
    .out_vld(out_valid), .blue(blue_out), .green(green_out), .red(red_out)
  );

endmodule

// ----- rtl/core/hhce_checker.sv -----
// Port-level checks of the color enhancement core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hhce_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] blue_in,
  input logic [7:0] green_in,
  input logic [7:0] red_in,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] blue_out,
  input logic [7:0] green_out,
  input logic [7:0] red_out,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [7:0] cfg_index,
  input logic [31:0] cfg_data
);

  // Hold a refused item
  `HHCE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(blue_out) && $stable(green_out) && $stable(red_out), "output item changed while stalled")

  // Input side stalls only behind a full, untaken output
  `HHCE_ASSERT_IMPL(a_in_ready, clk, rst, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")

  // Register writes are never refused
  `HHCE_ASSERT_IMPL(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "register write refused")

  // Pipeline empty after reset
  `HHCE_ASSERT_IMPL(a_reset_empty, clk, rst, $past(rst), !out_valid, "output item right after reset")

endmodule

bind hsv_hue_curve_color_enhance_core hhce_checker u_hhce_checker (.*);
